### rtl/bit_vector_set_engine_top_assert.svh
// Assertion macros for the bit vector set engine checker.
// Needs clk and rst_n in the scope where a macro is used.
`ifndef BIT_VECTOR_SET_ENGINE_TOP_ASSERT_SVH
`define BIT_VECTOR_SET_ENGINE_TOP_ASSERT_SVH

// Same-cycle implication, disabled during reset
`define BVS_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled during reset
`define BVS_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/bvs_pkg.sv
// Shared types, constants and helper functions for the bit vector set engine.
// No dependencies; imported by every module of the block but the checker.
package bvs_pkg;

    localparam int WORD_BITS  = 32;
    localparam int MAX_BITS   = 1024;
    localparam int NWORDS     = MAX_BITS / WORD_BITS;
    localparam int WORD_SHIFT = $clog2(WORD_BITS);
    localparam int IDX_W      = $clog2(NWORDS);
    localparam int LEN_W      = 11;
    localparam int POS_W      = WORD_SHIFT + IDX_W;
    localparam int CNT_W      = WORD_SHIFT + 1;

    typedef logic [WORD_BITS-1:0] word_t;
    typedef logic [IDX_W-1:0]     idx_t;
    typedef logic [LEN_W-1:0]     len_t;
    typedef logic [CNT_W-1:0]     cnt_t;
    typedef logic [POS_W-1:0]     pos_t;

    // Function codes of an input item
    localparam logic [2:0] FN_UNION     = 3'd0;
    localparam logic [2:0] FN_INTERSECT = 3'd1;
    localparam logic [2:0] FN_DISJOINT  = 3'd2;
    localparam logic [2:0] FN_RANGE     = 3'd3;
    localparam logic [2:0] FN_LIST      = 3'd4;
    localparam logic [2:0] FN_WRITE     = 3'd5;
    localparam logic [2:0] FN_READ      = 3'd6;
    localparam logic [2:0] FN_RSVD      = 3'd7;

    // Word unit operations
    typedef enum logic [2:0] {
        ALU_PASS,
        ALU_OR,
        ALU_AND,
        ALU_SET,
        ALU_KEEP,
        ALU_LOAD
    } alu_op_t;

    typedef struct packed {
        alu_op_t op;
        cnt_t    hi_cnt;
        cnt_t    lo_cnt;
        word_t   old_word;
        word_t   operand;
    } alu_req_t;

    typedef struct packed {
        word_t new_word;
        logic  hit;
        logic  changed;
    } alu_rsp_t;

    typedef struct packed {
        logic  rd_en;
        idx_t  rd_addr;
        logic  wr_en;
        idx_t  wr_addr;
        word_t wr_data;
        logic  trim_en;
        len_t  trim_len;
    } mem_cmd_t;

    typedef struct packed {
        logic  valid;
        logic  flag;
        pos_t  position;
        logic  found;
        logic  last;
        word_t word;
        len_t  length;
    } emit_t;

    // Ones in the low n bits, n up to WORD_BITS
    function automatic word_t low_mask(input cnt_t n);
        word_t m;
        if (n >= cnt_t'(WORD_BITS))
            m = '1;
        else
            m = (word_t'(1) << n) - word_t'(1);
        return m;
    endfunction

    // Number of bits of word i that lie below bit position len
    function automatic cnt_t region_cnt(input len_t len, input idx_t i);
        len_t base;
        len_t diff;
        cnt_t cnt;
        base = len_t'({i, {WORD_SHIFT{1'b0}}});
        diff = len - base;
        if (len <= base)
            cnt = '0;
        else if (diff >= len_t'(WORD_BITS))
            cnt = cnt_t'(WORD_BITS);
        else
            cnt = diff[CNT_W-1:0];
        return cnt;
    endfunction

endpackage

### rtl/bvs_alu.sv
// Shared word unit: builds a bit mask and merges operand into a stored word.
// Depends on bvs_pkg.
module bvs_alu
    import bvs_pkg::*;
(
    input  alu_req_t req,
    output alu_rsp_t rsp
);

    word_t mask;
    word_t result;

    // Mask covers bits lo_cnt .. hi_cnt-1
    assign mask = low_mask(req.hi_cnt) & ~low_mask(req.lo_cnt);

    // Merge
    always_comb
    begin
        case (req.op)
            ALU_PASS: result = req.old_word;
            ALU_OR:   result = req.old_word | (req.operand & mask);
            ALU_AND:  result = (req.old_word & ~mask) | (req.old_word & req.operand & mask);
            ALU_SET:  result = req.old_word | mask;
            ALU_KEEP: result = req.old_word & mask;
            ALU_LOAD: result = req.operand & mask;
            default:  result = req.old_word;
        endcase
    end

    assign rsp.new_word = result;
    assign rsp.hit      = |(req.old_word & req.operand & mask);
    assign rsp.changed  = (result != req.old_word);

endmodule

### rtl/bvs_mem.sv
// Word store of the set with per-word valid bits; an invalid word reads zero.
// One read and one write port, registered read data. Depends on bvs_pkg.
module bvs_mem
    import bvs_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  mem_cmd_t cmd,
    output word_t    rd_word
);

    word_t              mem_array [NWORDS];
    word_t              rd_data_reg;
    logic               rd_valid_reg;
    logic [NWORDS-1:0]  valid_reg;
    logic [NWORDS-1:0]  valid_next;

    // Storage array and read data
    always_ff @(posedge clk)
    begin
        if (cmd.wr_en)
        begin
            mem_array[cmd.wr_addr] <= cmd.wr_data;
        end
        if (cmd.rd_en)
        begin
            rd_data_reg <= mem_array[cmd.rd_addr];
        end
    end

    // Valid bits: trim drops whole words at or beyond the new length
    always_comb
    begin
        valid_next = valid_reg;
        if (cmd.trim_en)
        begin
            for (int i = 0; i < NWORDS; i++)
            begin
                if (int'(cmd.trim_len) <= i * WORD_BITS)
                    valid_next[i] = 1'b0;
            end
        end
        if (cmd.wr_en)
        begin
            valid_next[cmd.wr_addr] = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
            if (cmd.rd_en)
                rd_valid_reg <= valid_reg[cmd.rd_addr];
        end
    end

    assign rd_word = rd_valid_reg ? rd_data_reg : '0;

endmodule

### rtl/bvs_seq.sv
// Sequencer: takes an item, steps the word store and shared word unit through
// the operation and hands result items to the output register. Depends on bvs_pkg.
module bvs_seq
    import bvs_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        item_valid,
    input  logic [2:0]  func,
    input  idx_t        word_index,
    input  word_t       other_word,
    input  len_t        other_length,
    input  pos_t        first_bit,
    input  pos_t        last_bit,
    input  logic        is_last,
    output logic        item_stall,
    output mem_cmd_t    mem_cmd,
    input  word_t       rd_word,
    output alu_req_t    alu_req,
    input  alu_rsp_t    alu_rsp,
    input  logic        out_free,
    output emit_t       emit
);

    localparam logic [2:0] S_IDLE    = 3'd0;
    localparam logic [2:0] S_EXEC    = 3'd1;
    localparam logic [2:0] S_RD      = 3'd2;
    localparam logic [2:0] S_RNG     = 3'd3;
    localparam logic [2:0] S_LIST_LD = 3'd4;
    localparam logic [2:0] S_WALK    = 3'd5;
    localparam logic [2:0] S_WR_MASK = 3'd6;
    localparam logic [2:0] S_WR_IDX  = 3'd7;

    logic [2:0] state_reg, state_next;
    len_t       set_len_reg, set_len_next;
    logic       changed_reg, changed_next;
    logic       disjoint_reg, disjoint_next;

    logic [2:0] func_reg, func_next;
    idx_t       idx_reg, idx_next;
    word_t      opw_reg, opw_next;
    len_t       olen_reg, olen_next;
    logic       is_last_reg, is_last_next;
    idx_t       cur_reg, cur_next;
    idx_t       fw_reg, fw_next;
    idx_t       lw_reg, lw_next;
    logic [WORD_SHIFT-1:0] lo_reg, lo_next;
    logic [WORD_SHIFT-1:0] hi_reg, hi_next;
    logic [WORD_SHIFT-1:0] bit_reg, bit_next;
    word_t      word_reg, word_next;
    word_t      rest_reg, rest_next;

    len_t       olen_sat;
    len_t       mlen;
    pos_t       last_clip;
    logic       rng_ok;
    logic       rest_done;

    // Operand length saturates at the set capacity
    assign olen_sat = (other_length > len_t'(MAX_BITS)) ? len_t'(MAX_BITS) : other_length;
    assign mlen     = (set_len_reg < olen_reg) ? set_len_reg : olen_reg;

    // Range clipped to the current length
    assign last_clip = (len_t'(last_bit) >= set_len_reg) ? pos_t'(set_len_reg - len_t'(1))
                                                          : last_bit;
    assign rng_ok    = (set_len_reg != '0) && (first_bit <= last_bit)
                       && (len_t'(first_bit) < set_len_reg);

    assign rest_done  = (rest_reg[WORD_BITS-1:1] == '0);
    assign item_stall = (state_reg != S_IDLE);

    // Next-state and datapath control
    always_comb
    begin
        state_next    = state_reg;
        set_len_next  = set_len_reg;
        changed_next  = changed_reg;
        disjoint_next = disjoint_reg;
        func_next     = func_reg;
        idx_next      = idx_reg;
        opw_next      = opw_reg;
        olen_next     = olen_reg;
        is_last_next  = is_last_reg;
        cur_next      = cur_reg;
        fw_next       = fw_reg;
        lw_next       = lw_reg;
        lo_next       = lo_reg;
        hi_next       = hi_reg;
        bit_next      = bit_reg;
        word_next     = word_reg;
        rest_next     = rest_reg;

        mem_cmd = '0;
        emit    = '0;
        emit.length = set_len_reg;

        alu_req.op       = ALU_PASS;
        alu_req.hi_cnt   = '0;
        alu_req.lo_cnt   = '0;
        alu_req.old_word = rd_word;
        alu_req.operand  = opw_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (item_valid)
                begin
                    func_next    = func;
                    idx_next     = word_index;
                    opw_next     = other_word;
                    olen_next    = olen_sat;
                    is_last_next = is_last;
                    unique case (func) inside
                        FN_UNION, FN_INTERSECT, FN_DISJOINT, FN_READ, FN_RSVD:
                        begin
                            mem_cmd.rd_en   = 1'b1;
                            mem_cmd.rd_addr = word_index;
                            state_next      = S_EXEC;
                        end
                        FN_RANGE:
                        begin
                            if (rng_ok)
                            begin
                                cur_next        = first_bit[POS_W-1:WORD_SHIFT];
                                fw_next         = first_bit[POS_W-1:WORD_SHIFT];
                                lw_next         = last_clip[POS_W-1:WORD_SHIFT];
                                lo_next         = first_bit[WORD_SHIFT-1:0];
                                hi_next         = last_clip[WORD_SHIFT-1:0];
                                mem_cmd.rd_en   = 1'b1;
                                mem_cmd.rd_addr = first_bit[POS_W-1:WORD_SHIFT];
                                state_next      = S_RNG;
                            end
                            else
                            begin
                                mem_cmd.rd_en   = 1'b1;
                                mem_cmd.rd_addr = word_index;
                                state_next      = S_EXEC;
                            end
                        end
                        FN_LIST:
                        begin
                            mem_cmd.rd_en   = 1'b1;
                            mem_cmd.rd_addr = word_index;
                            state_next      = S_LIST_LD;
                        end
                        FN_WRITE:
                        begin
                            mem_cmd.trim_en  = 1'b1;
                            mem_cmd.trim_len = olen_sat;
                            set_len_next     = olen_sat;
                            if (olen_sat[WORD_SHIFT-1:0] != '0)
                            begin
                                // partial boundary word needs masking
                                cur_next        = olen_sat[POS_W-1:WORD_SHIFT];
                                mem_cmd.rd_en   = 1'b1;
                                mem_cmd.rd_addr = olen_sat[POS_W-1:WORD_SHIFT];
                                state_next      = S_WR_MASK;
                            end
                            else
                            begin
                                state_next = S_WR_IDX;
                            end
                        end
                    endcase
                end
            end

            S_EXEC:
            begin
                case (func_reg) inside
                    FN_UNION:
                    begin
                        alu_req.op     = ALU_OR;
                        alu_req.hi_cnt = region_cnt(olen_reg, idx_reg);
                    end
                    FN_INTERSECT:
                    begin
                        alu_req.op     = ALU_AND;
                        alu_req.hi_cnt = region_cnt(mlen, idx_reg);
                    end
                    FN_DISJOINT:
                    begin
                        alu_req.hi_cnt = region_cnt(mlen, idx_reg);
                    end
                    default:
                    begin
                        alu_req.op = ALU_PASS;
                    end
                endcase

                if (out_free)
                begin
                    emit.valid = 1'b1;
                    emit.last  = 1'b1;
                    emit.word  = alu_rsp.new_word;
                    case (func_reg) inside
                        FN_UNION, FN_INTERSECT:
                        begin
                            mem_cmd.wr_en   = 1'b1;
                            mem_cmd.wr_addr = idx_reg;
                            mem_cmd.wr_data = alu_rsp.new_word;
                            emit.flag       = changed_reg | alu_rsp.changed;
                            changed_next    = is_last_reg ? 1'b0
                                                          : (changed_reg | alu_rsp.changed);
                            if (is_last_reg)
                                disjoint_next = 1'b1;
                            if ((func_reg == FN_UNION) && (olen_reg > set_len_reg))
                            begin
                                set_len_next = olen_reg;
                                emit.length  = olen_reg;
                            end
                        end
                        FN_DISJOINT:
                        begin
                            emit.flag     = disjoint_reg & ~alu_rsp.hit;
                            disjoint_next = is_last_reg ? 1'b1 : (disjoint_reg & ~alu_rsp.hit);
                            if (is_last_reg)
                                changed_next = 1'b0;
                        end
                        default:
                        begin
                            emit.flag = 1'b0;
                        end
                    endcase
                    state_next = S_IDLE;
                end
            end

            S_RD:
            begin
                mem_cmd.rd_en   = 1'b1;
                mem_cmd.rd_addr = idx_reg;
                state_next      = S_EXEC;
            end

            S_RNG:
            begin
                // fill one word of the range
                alu_req.op     = ALU_SET;
                alu_req.lo_cnt = (cur_reg == fw_reg) ? cnt_t'(lo_reg) : '0;
                alu_req.hi_cnt = (cur_reg == lw_reg) ? (cnt_t'(hi_reg) + cnt_t'(1))
                                                     : cnt_t'(WORD_BITS);
                mem_cmd.wr_en   = 1'b1;
                mem_cmd.wr_addr = cur_reg;
                mem_cmd.wr_data = alu_rsp.new_word;
                if (cur_reg == lw_reg)
                begin
                    state_next = S_RD;
                end
                else
                begin
                    cur_next        = cur_reg + idx_t'(1);
                    mem_cmd.rd_en   = 1'b1;
                    mem_cmd.rd_addr = cur_reg + idx_t'(1);
                end
            end

            S_LIST_LD:
            begin
                word_next  = rd_word;
                rest_next  = rd_word;
                bit_next   = '0;
                state_next = S_WALK;
            end

            S_WALK:
            begin
                if (word_reg == '0)
                begin
                    // empty word: single result, nothing found
                    if (out_free)
                    begin
                        emit.valid = 1'b1;
                        emit.last  = 1'b1;
                        state_next = S_IDLE;
                    end
                end
                else if (rest_reg[0])
                begin
                    if (out_free)
                    begin
                        emit.valid    = 1'b1;
                        emit.found    = 1'b1;
                        emit.position = {idx_reg, bit_reg};
                        emit.last     = rest_done;
                        emit.word     = word_reg;
                        if (rest_done)
                        begin
                            state_next = S_IDLE;
                        end
                        else
                        begin
                            rest_next = rest_reg >> 1;
                            bit_next  = bit_reg + WORD_SHIFT'(1);
                        end
                    end
                end
                else
                begin
                    rest_next = rest_reg >> 1;
                    bit_next  = bit_reg + WORD_SHIFT'(1);
                end
            end

            S_WR_MASK:
            begin
                alu_req.op      = ALU_KEEP;
                alu_req.hi_cnt  = region_cnt(olen_reg, cur_reg);
                mem_cmd.wr_en   = 1'b1;
                mem_cmd.wr_addr = cur_reg;
                mem_cmd.wr_data = alu_rsp.new_word;
                state_next      = S_WR_IDX;
            end

            S_WR_IDX:
            begin
                alu_req.op     = ALU_LOAD;
                alu_req.hi_cnt = region_cnt(olen_reg, idx_reg);
                if (out_free)
                begin
                    mem_cmd.wr_en   = 1'b1;
                    mem_cmd.wr_addr = idx_reg;
                    mem_cmd.wr_data = alu_rsp.new_word;
                    emit.valid      = 1'b1;
                    emit.last       = 1'b1;
                    emit.word       = alu_rsp.new_word;
                    state_next      = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            set_len_reg  <= '0;
            changed_reg  <= 1'b0;
            disjoint_reg <= 1'b1;
        end
        else
        begin
            state_reg    <= state_next;
            set_len_reg  <= set_len_next;
            changed_reg  <= changed_next;
            disjoint_reg <= disjoint_next;
        end
    end

    // Item fields and walk registers
    always_ff @(posedge clk)
    begin
        func_reg    <= func_next;
        idx_reg     <= idx_next;
        opw_reg     <= opw_next;
        olen_reg    <= olen_next;
        is_last_reg <= is_last_next;
        cur_reg     <= cur_next;
        fw_reg      <= fw_next;
        lw_reg      <= lw_next;
        lo_reg      <= lo_next;
        hi_reg      <= hi_next;
        bit_reg     <= bit_next;
        word_reg    <= word_next;
        rest_reg    <= rest_next;
    end

endmodule

### rtl/bit_vector_set_engine_top.sv
// Bit vector set engine; one item at a time. Union, intersect, disjoint test and read:
// read the word, then apply and emit. Write word: trim, mask a partial boundary word, write.
// Range add: fill each word touched, then read the indexed word (only that when nothing
// is set). List ones: load the word, walk its bits to the last set one. The next item is
// taken once the last result is registered; result stalls delay it. Rate is set by the
// one word store and shared unit. Reset clears length and flags and marks every word invalid; no clearing pass.
module bit_vector_set_engine_top
    import bvs_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        item_valid,
    output logic        item_stall,
    input  logic [2:0]  func,
    input  logic [4:0]  word_index,
    input  logic [31:0] other_word,
    input  logic [10:0] other_length,
    input  logic [9:0]  first_bit,
    input  logic [9:0]  last_bit,
    input  logic        is_last,
    output logic        result_valid,
    input  logic        result_stall,
    output logic        flag,
    output logic [9:0]  position,
    output logic        found,
    output logic        last_of_run,
    output logic [31:0] word_out,
    output logic [10:0] length_out
);

    mem_cmd_t mem_cmd;
    word_t    rd_word;
    alu_req_t alu_req;
    alu_rsp_t alu_rsp;
    emit_t    emit;
    logic     out_free;
    logic     result_valid_reg;
    emit_t    result_reg;

    bvs_mem u_mem (
        .clk     (clk),
        .rst_n   (rst_n),
        .cmd     (mem_cmd),
        .rd_word (rd_word)
    );

    bvs_alu u_alu (
        .req (alu_req),
        .rsp (alu_rsp)
    );

    bvs_seq u_seq (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .func         (func),
        .word_index   (word_index),
        .other_word   (other_word),
        .other_length (other_length),
        .first_bit    (first_bit),
        .last_bit     (last_bit),
        .is_last      (is_last),
        .item_stall   (item_stall),
        .mem_cmd      (mem_cmd),
        .rd_word      (rd_word),
        .alu_req      (alu_req),
        .alu_rsp      (alu_rsp),
        .out_free     (out_free),
        .emit         (emit)
    );

    // Output register: free when empty or being taken this cycle
    assign out_free = !result_valid_reg || !result_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            result_valid_reg <= 1'b0;
        else if (emit.valid)
            result_valid_reg <= 1'b1;
        else if (!result_stall)
            result_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (emit.valid)
            result_reg <= emit;
    end

    assign result_valid = result_valid_reg;
    assign flag         = result_reg.flag;
    assign position     = result_reg.position;
    assign found        = result_reg.found;
    assign last_of_run  = result_reg.last;
    assign word_out     = result_reg.word;
    assign length_out   = result_reg.length;

endmodule

### rtl/bvs_checker.sv
// Port-level checker for the bit vector set engine, bound to the top level.
// Depends on bit_vector_set_engine_top_assert.svh.
`include "bit_vector_set_engine_top_assert.svh"

module bvs_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        item_valid,
    input  logic        item_stall,
    input  logic        result_valid,
    input  logic        result_stall,
    input  logic [9:0]  position,
    input  logic        found,
    input  logic        last_of_run,
    input  logic [31:0] word_out
);

    // A held result keeps its payload
    `BVS_ASSERT_NEXT(a_hold, result_valid && result_stall, result_valid && $stable(word_out) && $stable(position) && $stable(last_of_run), "result changed while stalled")

    // Every accepted item keeps the block busy in the cycle after it is taken
    `BVS_ASSERT_NEXT(a_busy, item_valid && !item_stall, item_stall, "item taken without busy cycle")

    // A result without found reports position zero
    `BVS_ASSERT_NOW(a_empty, result_valid && !found, position == 10'd0, "position set without found")

    // A found position is a set bit of the reported word
    `BVS_ASSERT_NOW(a_bit, result_valid && found, word_out[position[4:0]], "found bit not set in word")

    // Only list ones results come in runs
    `BVS_ASSERT_NOW(a_run, result_valid && !last_of_run, found, "multi-result run without found")

endmodule

bind bit_vector_set_engine_top bvs_checker u_bvs_checker (.*);

### tb/bvs_tb_pkg.sv
// Scoreboard for the bit vector set engine testbench: its own copy of the stored
// set and a queue of the results that copy predicts. Depends on bvs_pkg.
package bvs_tb_pkg;
    import bvs_pkg::*;

    typedef struct {
        logic        flag;
        logic [9:0]  position;
        logic        found;
        logic        last_of_run;
        logic [31:0] word_out;
        logic [10:0] length_out;
    } set_result_t;

    class set_scoreboard;
        logic [31:0] words [NWORDS];
        int          set_len;
        bit          changed_acc;
        bit          disjoint_acc;
        set_result_t expected_q [$];
        int          errors;

        function new();
            foreach (words[i])
                words[i] = '0;
            set_len      = 0;
            changed_acc  = 1'b0;
            disjoint_acc = 1'b1;
            errors       = 0;
        endfunction

        // ones in the low n bits of a word
        function logic [31:0] low_ones(int n);
            logic [63:0] m;
            if (n >= WORD_BITS)
                return '1;
            m = (64'd1 << n) - 64'd1;
            return m[31:0];
        endfunction

        // bits of word i lying below bit position len
        function logic [31:0] span(int i, int len);
            int base;
            base = i * WORD_BITS;
            if (len <= base)
                return '0;
            return low_ones(len - base);
        endfunction

        function void push(logic fl, int pos, logic fnd, logic lst, logic [31:0] w);
            set_result_t r;
            r.flag        = fl;
            r.position    = 10'(pos);
            r.found       = fnd;
            r.last_of_run = lst;
            r.word_out    = w;
            r.length_out  = 11'(set_len);
            expected_q.push_back(r);
        endfunction

        // Apply one accepted item to the set and queue the results it causes
        function void note_item(logic [2:0] fn, logic [4:0] idx, logic [31:0] w,
                                logic [10:0] olen_in, logic [9:0] fb, logic [9:0] lb,
                                logic il);
            int          olen;
            int          mlen;
            int          i;
            int          rng_first;
            int          rng_last;
            int          fw;
            int          lw;
            int          lo_b;
            int          hi_b;
            logic [31:0] op;
            logic [31:0] old;
            logic [31:0] rmask;
            logic [31:0] rest;
            logic        fl;

            olen = int'(olen_in);
            if (olen > MAX_BITS)
                olen = MAX_BITS;
            i = int'(idx);

            case (fn)
                FN_UNION, FN_INTERSECT, FN_DISJOINT:
                begin
                    mlen = (set_len < olen) ? set_len : olen;
                    op   = w & span(i, olen);
                    old  = words[i];
                    if (fn == FN_UNION)
                    begin
                        if (olen > set_len)
                            set_len = olen;
                        words[i] = old | op;
                        if (words[i] != old)
                            changed_acc = 1'b1;
                        fl = changed_acc;
                    end
                    else if (fn == FN_INTERSECT)
                    begin
                        // bits at or above the shorter length stay as they are
                        rmask    = span(i, mlen);
                        words[i] = (old & ~rmask) | (old & op & rmask);
                        if (words[i] != old)
                            changed_acc = 1'b1;
                        fl = changed_acc;
                    end
                    else
                    begin
                        if ((old & op & span(i, mlen)) != 0)
                            disjoint_acc = 1'b0;
                        fl = disjoint_acc;
                    end
                    push(fl, 0, 1'b0, 1'b1, words[i]);
                    // the last operand word restarts accumulation
                    if (il)
                    begin
                        changed_acc  = 1'b0;
                        disjoint_acc = 1'b1;
                    end
                end
                FN_RANGE:
                begin
                    rng_first = int'(fb);
                    rng_last  = int'(lb);
                    if (set_len != 0 && rng_first <= rng_last && rng_first < set_len)
                    begin
                        if (rng_last >= set_len)
                            rng_last = set_len - 1;
                        fw = rng_first / WORD_BITS;
                        lw = rng_last / WORD_BITS;
                        for (int k = fw; k <= lw; k++)
                        begin
                            lo_b = (k == fw) ? rng_first % WORD_BITS : 0;
                            hi_b = (k == lw) ? rng_last % WORD_BITS : WORD_BITS - 1;
                            words[k] = words[k] | (low_ones(hi_b + 1) & ~low_ones(lo_b));
                        end
                    end
                    push(1'b0, 0, 1'b0, 1'b1, words[i]);
                end
                FN_LIST:
                begin
                    if (words[i] == 0)
                        push(1'b0, 0, 1'b0, 1'b1, '0);
                    else
                    begin
                        for (int b = 0; b < WORD_BITS; b++)
                        begin
                            if (words[i][b])
                            begin
                                rest = words[i] & ~low_ones(b + 1);
                                push(1'b0, i * WORD_BITS + b, 1'b1, rest == 0, words[i]);
                            end
                        end
                    end
                end
                FN_WRITE:
                begin
                    // new length clears everything beyond it first
                    set_len = olen;
                    for (int k = 0; k < NWORDS; k++)
                        words[k] = words[k] & span(k, olen);
                    words[i] = w & span(i, olen);
                    push(1'b0, 0, 1'b0, 1'b1, words[i]);
                end
                default:
                    push(1'b0, 0, 1'b0, 1'b1, words[i]);
            endcase
        endfunction

        function void check_result(set_result_t got);
            set_result_t want;
            if (expected_q.size() == 0)
            begin
                errors++;
                if (errors <= 10)
                    $display("ERROR: result with none expected: word_out=%h length_out=%0d",
                             got.word_out, got.length_out);
                return;
            end
            want = expected_q.pop_front();
            if (got.flag !== want.flag || got.position !== want.position ||
                got.found !== want.found || got.last_of_run !== want.last_of_run ||
                got.word_out !== want.word_out || got.length_out !== want.length_out)
            begin
                errors++;
                if (errors <= 10)
                    $display({"ERROR: result differs (expected/actual): flag %b/%b ",
                              "position %0d/%0d found %b/%b last %b/%b ",
                              "word %h/%h length %0d/%0d"},
                             want.flag, got.flag, want.position, got.position,
                             want.found, got.found, want.last_of_run, got.last_of_run,
                             want.word_out, got.word_out, want.length_out, got.length_out);
            end
        endfunction

        function int pending();
            return expected_q.size();
        endfunction
    endclass

endpackage

### tb/bit_vector_set_engine_top_tb.sv
// Testbench for bit_vector_set_engine_top: directed then random items with random
// idling on both sides. Depends on bvs_pkg, bvs_tb_pkg and the block's RTL.
module bit_vector_set_engine_top_tb;
    import bvs_pkg::*;
    import bvs_tb_pkg::*;

    localparam int IDLE_LIMIT   = 2000;
    localparam int TAIL_CYCLES  = 40;
    localparam int RANDOM_ITEMS = 75;

    logic        clk;
    logic        rst_n;
    logic        item_valid;
    logic        item_stall;
    logic [2:0]  func;
    logic [4:0]  word_index;
    logic [31:0] other_word;
    logic [10:0] other_length;
    logic [9:0]  first_bit;
    logic [9:0]  last_bit;
    logic        is_last;
    logic        result_valid;
    logic        result_stall;
    logic        flag;
    logic [9:0]  position;
    logic        found;
    logic        last_of_run;
    logic [31:0] word_out;
    logic [10:0] length_out;

    set_scoreboard sb;
    set_result_t   got;
    bit            idle_on;
    int            items_sent   = 0;
    int            stall_left   = 0;
    int            quiet_cycles = 0;

    bit_vector_set_engine_top uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .func         (func),
        .word_index   (word_index),
        .other_word   (other_word),
        .other_length (other_length),
        .first_bit    (first_bit),
        .last_bit     (last_bit),
        .is_last      (is_last),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .flag         (flag),
        .position     (position),
        .found        (found),
        .last_of_run  (last_of_run),
        .word_out     (word_out),
        .length_out   (length_out)
    );

    always #2 clk = ~clk;

    // Result side: check each accepted result, then stall a random while
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (result_valid && !result_stall)
            begin
                got.flag        = flag;
                got.position    = position;
                got.found       = found;
                got.last_of_run = last_of_run;
                got.word_out    = word_out;
                got.length_out  = length_out;
                sb.check_result(got);
                stall_left = idle_on ? $urandom_range(0, 8) : 0;
            end
            if (stall_left > 0)
            begin
                result_stall <= 1'b1;
                stall_left--;
            end
            else
                result_stall <= 1'b0;
        end
    end

    // Watchdog: too long without any handshake ends the run
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((item_valid && !item_stall) || (result_valid && !result_stall))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= IDLE_LIMIT)
            begin
                $display("Mismatches found");
                $finish;
            end
        end
    end

    function automatic logic [31:0] pick_word();
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return '1;
            2:       return 32'd1 << $urandom_range(0, 31);
            default: return $urandom();
        endcase
    endfunction

    // mostly in range; some full length, some beyond it (saturates)
    function automatic logic [10:0] pick_length();
        case ($urandom_range(0, 9))
            0:       return 11'd1024;
            1:       return 11'($urandom_range(1025, 2047));
            2:       return 11'($urandom_range(0, 64));
            default: return 11'($urandom_range(0, 1024));
        endcase
    endfunction

    // Present one item after a random gap and hold it until taken
    task automatic send_item(input logic [2:0] fn, input logic [4:0] idx,
                             input logic [31:0] w, input logic [10:0] olen,
                             input logic [9:0] fb, input logic [9:0] lb, input logic il);
        int gap;
        gap = idle_on ? $urandom_range(0, 8) : 0;
        if (gap > 0)
        begin
            item_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        item_valid   <= 1'b1;
        func         <= fn;
        word_index   <= idx;
        other_word   <= w;
        other_length <= olen;
        first_bit    <= fb;
        last_bit     <= lb;
        is_last      <= il;
        @(posedge clk);
        while (item_stall)
            @(posedge clk);
        sb.note_item(fn, idx, w, olen, fb, lb, il);
        items_sent++;
    endtask

    // Hold off the sender until every expected result has come back
    task automatic wait_drained();
        item_valid <= 1'b0;
        @(posedge clk);
        while (sb.pending() != 0)
            @(posedge clk);
    endtask

    initial
    begin
        logic [2:0]  fn;
        logic [10:0] olen;
        logic [9:0]  fb;
        logic [9:0]  lb;
        logic        il;
        int          kind;
        int          n;
        int          base_idx;
        int          start_count;
        int          round;

        sb           = new();
        clk          = 1'b0;
        rst_n        = 1'b0;
        item_valid   = 1'b0;
        func         = FN_READ;
        word_index   = '0;
        other_word   = '0;
        other_length = '0;
        first_bit    = '0;
        last_bit     = '0;
        is_last      = 1'b0;
        result_stall = 1'b0;
        idle_on      = 1'b1;
        round        = 0;

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: empty set, masking, saturation, accumulation, range edges
        send_item(FN_READ, 0, '0, 0, 0, 0, 0);
        send_item(FN_LIST, 0, '0, 0, 0, 0, 0);                 // empty word
        send_item(FN_RANGE, 0, '0, 0, 0, 1023, 0);             // zero length: no-op
        send_item(FN_WRITE, 0, 32'hFFFF_FFFF, 40, 0, 0, 0);
        send_item(FN_WRITE, 1, 32'hFFFF_FFFF, 40, 0, 0, 1);    // masked to length
        send_item(FN_LIST, 1, '0, 0, 0, 0, 0);
        send_item(FN_UNION, 31, 32'h8000_0001, 1024, 0, 0, 0);
        send_item(FN_UNION, 31, 32'h8000_0001, 1024, 0, 0, 1); // flag holds, then clears
        send_item(FN_UNION, 5, 32'hAAAA_AAAA, 11'h7FF, 0, 0, 1);
        send_item(FN_UNION, 2, 32'hFFFF_FFFF, 70, 0, 0, 1);    // operand masked
        send_item(FN_INTERSECT, 2, 32'h0000_000F, 1024, 0, 0, 0);
        send_item(FN_INTERSECT, 31, 32'h0, 100, 0, 0, 1);      // beyond shorter length
        send_item(FN_DISJOINT, 5, 32'h5555_5555, 1024, 0, 0, 0);
        send_item(FN_DISJOINT, 5, 32'hFFFF_FFFF, 1024, 0, 0, 1);
        send_item(FN_DISJOINT, 5, 32'h0000_FFFF, 1024, 0, 0, 1);
        send_item(FN_RANGE, 7, '0, 0, 0, 1023, 0);             // fill everything
        send_item(FN_WRITE, 0, '0, 100, 0, 0, 0);              // shrink, clear tail
        send_item(FN_RANGE, 3, '0, 0, 40, 35, 0);              // first above last
        send_item(FN_RANGE, 3, '0, 0, 100, 1023, 0);           // first at length
        send_item(FN_RANGE, 1, '0, 0, 33, 1023, 0);            // last clipped
        send_item(FN_LIST, 3, '0, 0, 0, 0, 0);
        send_item(FN_WRITE, 31, 32'h8000_0000, 1024, 0, 0, 0);
        send_item(FN_LIST, 31, '0, 0, 0, 0, 0);                // top bit position
        send_item(FN_WRITE, 9, 32'h1234_5678, 0, 0, 0, 0);     // zero length clears all
        send_item(FN_RSVD, 31, '0, 0, 0, 0, 0);
        wait_drained();

        // Random: mostly operand streams, with stray items and pauses mixed in
        start_count = items_sent;
        while (items_sent - start_count < RANDOM_ITEMS)
        begin
            if (round % 8 == 0)
                idle_on = ($urandom_range(0, 2) != 0);
            round++;
            kind = $urandom_range(0, 11);
            if (kind <= 4)
            begin
                case ($urandom_range(0, 2))
                    0:       fn = FN_UNION;
                    1:       fn = FN_INTERSECT;
                    default: fn = FN_DISJOINT;
                endcase
                n        = $urandom_range(1, 5);
                base_idx = $urandom_range(0, 31);
                olen     = pick_length();
                for (int k = 0; k < n; k++)
                begin
                    il = (k == n - 1);
                    // occasionally a broken stream
                    if ($urandom_range(0, 9) == 0)
                        il = ~il;
                    send_item(fn, 5'(base_idx + k), pick_word(), olen,
                              10'($urandom()), 10'($urandom()), il);
                end
            end
            else if (kind == 5)
                send_item(FN_WRITE, 5'($urandom()), pick_word(), pick_length(),
                          10'($urandom()), 10'($urandom()), 1'($urandom()));
            else if (kind == 6)
            begin
                fb = 10'($urandom());
                lb = ($urandom_range(0, 1) != 0) ? 10'($urandom())
                                                 : fb + 10'($urandom_range(0, 70));
                send_item(FN_RANGE, 5'($urandom()), pick_word(), pick_length(),
                          fb, lb, 1'($urandom()));
            end
            else if (kind <= 8)
                send_item(FN_LIST, 5'($urandom()), pick_word(), pick_length(),
                          10'($urandom()), 10'($urandom()), 1'($urandom()));
            else if (kind == 9)
            begin
                fn = ($urandom_range(0, 1) != 0) ? FN_READ : FN_RSVD;
                send_item(fn, 5'($urandom()), pick_word(), pick_length(),
                          10'($urandom()), 10'($urandom()), 1'($urandom()));
            end
            else if (kind == 10)
                send_item(3'($urandom()), 5'($urandom()), $urandom(), 11'($urandom()),
                          10'($urandom()), 10'($urandom()), 1'($urandom()));
            else
                wait_drained();
        end

        wait_drained();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (sb.errors == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
